// ===== src/wwls_pkg.sv =====
// shared types, constants and helpers for the word wrap line segment block
// no dependencies
package wwls_pkg;

    localparam int POS_BITS    = 16;
    localparam int WIDTH_BITS  = 10;
    localparam int CMP_BITS    = (POS_BITS > WIDTH_BITS) ? POS_BITS : WIDTH_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [WIDTH_BITS-1:0] t_width;
    typedef logic [7:0]            t_char;

    localparam t_pos   POS_MAX      = '1;
    localparam t_width WIDTH_RESET  = WIDTH_BITS'(80);
    localparam t_char  CHAR_SPACE   = 8'd32;
    localparam t_char  CHAR_NEWLINE = 8'd10;

    // results caused by one input item: a first segment and an optional closing one
    typedef struct packed {
        t_pos begin0;
        t_pos end0;
        logic final0;
        logic two;
        t_pos begin1;
        t_pos end1;
    } t_entry;

    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? v : v + t_pos'(1);
    endfunction

endpackage

// ===== src/wwls_front.sv =====
// front part: accepts characters, keeps line state, classifies breaks
// depends on wwls_pkg
module wwls_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  wwls_pkg::t_char       i_char,
    input  logic                  i_eot,
    input  wwls_pkg::t_width      i_width,
    input  logic                  i_queue_ready,
    output logic                  o_push,
    output wwls_pkg::t_entry      o_entry
);
    import wwls_pkg::*;

    t_pos r_char_pos, n_char_pos;
    t_pos r_line_start, n_line_start;
    t_pos r_space_pos, n_space_pos;
    logic r_seen, n_seen;

    t_pos pos_i, pos_next, sp1, ls1, ls2, since, gap, brk_end;
    logic is_sp, is_nl, seen1, brk, hard, accept;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;

    always_comb begin
        pos_i    = r_char_pos;
        pos_next = sat_inc(pos_i);
        is_sp    = (i_char == CHAR_SPACE);
        is_nl    = (i_char == CHAR_NEWLINE);
        sp1      = (is_sp || is_nl) ? pos_i : r_space_pos;
        seen1    = r_seen || is_sp || is_nl;
        ls1      = is_nl ? pos_next : r_line_start;
        since    = (pos_next >= ls1) ? pos_next - ls1 : '0;
        brk      = (i_width != '0) && (CMP_BITS'(since) == CMP_BITS'(i_width));
        gap      = (pos_i >= sp1) ? pos_i - sp1 : '0;
        hard     = !seen1 || (CMP_BITS'(gap) >= CMP_BITS'(i_width));
        brk_end  = hard ? pos_next : sp1;
        ls2      = brk ? (hard ? pos_next : sat_inc(sp1)) : ls1;

        // newline and width break never coincide
        if (is_nl) begin
            o_entry.begin0 = r_line_start;
            o_entry.end0   = pos_i;
            o_entry.final0 = 1'b0;
        end else if (brk) begin
            o_entry.begin0 = ls1;
            o_entry.end0   = brk_end;
            o_entry.final0 = 1'b0;
        end else begin
            o_entry.begin0 = ls2;
            o_entry.end0   = pos_next;
            o_entry.final0 = 1'b1;
        end
        o_entry.two    = (is_nl || brk) && i_eot;
        o_entry.begin1 = ls2;
        o_entry.end1   = pos_next;

        o_push = accept && (i_width != '0) && (is_nl || brk || i_eot);
    end

    always_comb begin
        n_char_pos   = r_char_pos;
        n_line_start = r_line_start;
        n_space_pos  = r_space_pos;
        n_seen       = r_seen;
        if (accept) begin
            if (i_eot) begin
                n_char_pos   = '0;
                n_line_start = '0;
                n_space_pos  = '0;
                n_seen       = 1'b0;
            end else begin
                n_char_pos   = pos_next;
                n_line_start = ls2;
                n_space_pos  = sp1;
                n_seen       = seen1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos   <= '0;
            r_line_start <= '0;
            r_space_pos  <= '0;
            r_seen       <= 1'b0;
        end else begin
            r_char_pos   <= n_char_pos;
            r_line_start <= n_line_start;
            r_space_pos  <= n_space_pos;
            r_seen       <= n_seen;
        end
    end

endmodule

// ===== src/wwls_queue.sv =====
// short queue of classified result entries between front and back
// depends on wwls_pkg
module wwls_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wwls_pkg::t_entry      i_entry,
    output logic                  o_ready,
    input  logic                  i_pop,
    output logic                  o_valid,
    output wwls_pkg::t_entry      o_entry
);
    import wwls_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QIDX_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QIDX_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count, n_count;
    logic                  do_push, do_pop;

    assign o_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QIDX_BITS'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QIDX_BITS'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== src/wwls_back.sv =====
// back part: splits queue entries into segments and drives the output register
// depends on wwls_pkg
module wwls_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  wwls_pkg::t_entry              i_q_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*wwls_pkg::POS_BITS-1:0] o_data,
    output logic                          o_final,
    output logic                          o_last
);
    import wwls_pkg::*;

    logic                  r_valid, n_valid;
    logic                  r_pend, n_pend;
    t_pos                  r_pend_begin, r_pend_end;
    logic [2*POS_BITS-1:0] r_data;
    logic                  r_final, r_last;
    logic                  load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !r_pend && i_q_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_final = r_final;
    assign o_last  = r_last;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        if (load) begin
            if (r_pend) begin
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else begin
                n_valid = i_q_valid;
                n_pend  = i_q_valid && i_q_entry.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_data  <= {r_pend_end, r_pend_begin};
                r_final <= 1'b1;
                r_last  <= 1'b1;
            end else begin
                r_data       <= {i_q_entry.end0, i_q_entry.begin0};
                r_final      <= i_q_entry.final0;
                r_last       <= !i_q_entry.two;
                r_pend_begin <= i_q_entry.begin1;
                r_pend_end   <= i_q_entry.end1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

endmodule

// ===== src/word_wrap_line_segments.sv =====
// top level of the greedy word wrap block: front, entry queue, back
// depends on wwls_pkg, wwls_front, wwls_queue, wwls_back
// path: the first segment of a character passes through the entry queue and then
//   the output register before it can transfer
// throughput: one character per cycle while the queue has room; a character that
//   closes two segments holds the output; the queue soaks this up, sized by its depth
// reset: synchronous active low; clears line state, queue and output register,
//   width limit returns to 80; no clearing pass
module word_wrap_line_segments (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: width limit, zero mutes all segments
    input  logic                          i_cfg_we,
    input  logic [wwls_pkg::WIDTH_BITS-1:0] i_cfg_wdata,
    // character stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] character
    input  logic                          s_axis_tlast,   // end of text
    // segment stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*wwls_pkg::POS_BITS-1:0] m_axis_tdata, // line_begin, then line_end
    output logic                          m_axis_tuser,   // [0] final_line
    output logic                          m_axis_tlast    // last segment of this character
);
    import wwls_pkg::*;

    t_width r_width;
    logic   q_ready, q_valid, push, pop;
    t_entry push_entry, q_entry;

    // width limit register, user writes only while idle; block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // front: tracks line start and last space, decides newline, wrap and
    // closing segments for each character transfer
    wwls_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_char        (s_axis_tdata),
        .i_eot         (s_axis_tlast),
        .i_width       (r_width),
        .i_queue_ready (q_ready),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // queue decouples character intake from segment delivery
    wwls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // back: one segment per output transfer, second segment held aside
    wwls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_final   (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule
